/* src/assert_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros
// Shared wrappers for the concurrent checks of the class file parser.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked check, switched off while reset is high
`define CFSP_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// clocked check that also holds through reset
`define CFSP_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* src/cfsp_pkg.sv */
// ----------------------------------------------------------------------------
// cfsp_pkg
// Types, codes and phase tables of the class file stream parser.
// ----------------------------------------------------------------------------
`default_nettype none

package cfsp_pkg;

   localparam logic [31:0] CLASS_MAGIC = 32'hCAFE_BABE;

   localparam logic [31:0] TAG_UTF8      = 32'd1;
   localparam logic [31:0] TAG_CLASS     = 32'd7;
   localparam logic [31:0] TAG_METHODREF = 32'd10;
   localparam logic [31:0] TAG_NAMETYPE  = 32'd12;

   typedef enum logic [2:0] {
      ST_OK        = 3'd0,
      ST_TRUNC     = 3'd1,
      ST_BAD_MAGIC = 3'd2,
      ST_BAD_TAG   = 3'd3,
      ST_NOT_IMPL  = 3'd4
   } status_type;

   typedef enum logic [4:0] {
      TK_MINOR      = 5'd0,
      TK_MAJOR      = 5'd1,
      TK_POOL_COUNT = 5'd2,
      TK_POOL_TAG   = 5'd3,
      TK_CLASS_NAME = 5'd4,
      TK_MR_CLASS   = 5'd5,
      TK_MR_NAT     = 5'd6,
      TK_NAT_NAME   = 5'd7,
      TK_NAT_DESC   = 5'd8,
      TK_UTF8_LEN   = 5'd9,
      TK_ACCESS     = 5'd10,
      TK_THIS       = 5'd11,
      TK_SUPER      = 5'd12,
      TK_IFC_COUNT  = 5'd13,
      TK_FLD_COUNT  = 5'd14,
      TK_MTH_COUNT  = 5'd15,
      TK_MTH_ACCESS = 5'd16,
      TK_MTH_NAME   = 5'd17,
      TK_MTH_DESC   = 5'd18,
      TK_MTH_ACOUNT = 5'd19,
      TK_ATTR_NAME  = 5'd20,
      TK_ATTR_LEN   = 5'd21,
      TK_CLS_ACOUNT = 5'd22,
      TK_PAYLOAD    = 5'd23
   } token_kind_type;

   localparam int unsigned TK_LAST = 23;

   typedef enum logic [28:0] {
      PH_MAGIC   = 29'd1 << 0,
      PH_MINOR   = 29'd1 << 1,
      PH_MAJOR   = 29'd1 << 2,
      PH_PCOUNT  = 29'd1 << 3,
      PH_TAG     = 29'd1 << 4,
      PH_CLASS   = 29'd1 << 5,
      PH_MRCLS   = 29'd1 << 6,
      PH_MRNAT   = 29'd1 << 7,
      PH_NATNAME = 29'd1 << 8,
      PH_NATDESC = 29'd1 << 9,
      PH_ULEN    = 29'd1 << 10,
      PH_UTEXT   = 29'd1 << 11,
      PH_ACC     = 29'd1 << 12,
      PH_THIS    = 29'd1 << 13,
      PH_SUPER   = 29'd1 << 14,
      PH_IFC     = 29'd1 << 15,
      PH_FIELDS  = 29'd1 << 16,
      PH_MCOUNT  = 29'd1 << 17,
      PH_MACC    = 29'd1 << 18,
      PH_MNAME   = 29'd1 << 19,
      PH_MDESC   = 29'd1 << 20,
      PH_MACNT   = 29'd1 << 21,
      PH_ANAME   = 29'd1 << 22,
      PH_ALEN    = 29'd1 << 23,
      PH_ABODY   = 29'd1 << 24,
      PH_CACNT   = 29'd1 << 25,
      PH_CANAME  = 29'd1 << 26,
      PH_CALEN   = 29'd1 << 27,
      PH_CABODY  = 29'd1 << 28
   } phase_type;

   // index of the last byte of a field (field length minus one)
   function automatic logic [1:0] field_last(phase_type ph);
      logic [1:0] r;
      unique case (ph)
         PH_MAGIC, PH_ALEN, PH_CALEN: r = 2'd3;
         PH_TAG:                      r = 2'd0;
         default:                     r = 2'd1;
      endcase
      return r;
   endfunction

   function automatic logic is_payload(phase_type ph);
      return (ph == PH_UTEXT) || (ph == PH_ABODY) || (ph == PH_CABODY);
   endfunction

   function automatic token_kind_type phase_kind(phase_type ph);
      token_kind_type k;
      unique case (ph)
         PH_MAJOR:   k = TK_MAJOR;
         PH_PCOUNT:  k = TK_POOL_COUNT;
         PH_TAG:     k = TK_POOL_TAG;
         PH_CLASS:   k = TK_CLASS_NAME;
         PH_MRCLS:   k = TK_MR_CLASS;
         PH_MRNAT:   k = TK_MR_NAT;
         PH_NATNAME: k = TK_NAT_NAME;
         PH_NATDESC: k = TK_NAT_DESC;
         PH_ULEN:    k = TK_UTF8_LEN;
         PH_ACC:     k = TK_ACCESS;
         PH_THIS:    k = TK_THIS;
         PH_SUPER:   k = TK_SUPER;
         PH_IFC:     k = TK_IFC_COUNT;
         PH_FIELDS:  k = TK_FLD_COUNT;
         PH_MCOUNT:  k = TK_MTH_COUNT;
         PH_MACC:    k = TK_MTH_ACCESS;
         PH_MNAME:   k = TK_MTH_NAME;
         PH_MDESC:   k = TK_MTH_DESC;
         PH_MACNT:   k = TK_MTH_ACOUNT;
         PH_ANAME, PH_CANAME: k = TK_ATTR_NAME;
         PH_ALEN, PH_CALEN:   k = TK_ATTR_LEN;
         PH_CACNT:   k = TK_CLS_ACOUNT;
         PH_UTEXT, PH_ABODY, PH_CABODY: k = TK_PAYLOAD;
         default:    k = TK_MINOR;
      endcase
      return k;
   endfunction

endpackage

`default_nettype wire

/* src/cfsp_stream_if.sv */
// ----------------------------------------------------------------------------
// cfsp stream interfaces
// Valid/ready channels for class file bytes in and parse tokens out.
// ----------------------------------------------------------------------------
`default_nettype none

interface cfsp_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       end_of_file;

   modport source (output valid, output data_byte, output end_of_file, input ready);
   modport sink   (input valid, input data_byte, input end_of_file, output ready);
endinterface

interface cfsp_rsp_if;
   logic        valid;
   logic        ready;
   logic [4:0]  token_kind;
   logic [31:0] token_value;
   logic [15:0] item_number;
   logic [2:0]  status;
   logic        final_res;

   modport source (output valid, output token_kind, output token_value,
                   output item_number, output status, output final_res, input ready);
   modport sink   (input valid, input token_kind, input token_value,
                   input item_number, input status, input final_res, output ready);
endinterface

`default_nettype wire

/* src/class_file_stream_parser.sv */
// An accepted byte waits in the input register; its token is held in the result register.
// Throughput: one byte per cycle; a token is held until taken, and the byte behind it waits.
// Each byte is consumed in one pass through the phase decoder and counter update.
// Reset (synchronous, high): back to the magic field, counters cleared, channels empty.
// After the final token every further byte is accepted and dropped until reset.
// ----------------------------------------------------------------------------
// class_file_stream_parser
// Byte-serial class file parser emitting tokens for completed fields and payload bytes.
// ----------------------------------------------------------------------------
`default_nettype none

module class_file_stream_parser
   import cfsp_pkg::*;
(
   input  wire         clock,
   input  wire         reset,
   cfsp_req_if.sink    req_chan,
   cfsp_rsp_if.source  rsp_chan
);

   // input register
   logic       in_valid_ff;
   logic [7:0] in_byte_ff;
   logic       in_eof_ff;

   // parser state
   phase_type   phase_ff,  phase_in;
   logic [1:0]  bif_ff,    bif_in;
   logic [31:0] acc_ff,    acc_in;
   logic [15:0] pool_ff,   pool_in;
   logic [15:0] meth_ff,   meth_in;
   logic [15:0] attr_ff,   attr_in;
   logic [15:0] cattr_ff,  cattr_in;
   logic [31:0] pbl_ff,    pbl_in;
   logic [15:0] item_ff,   item_in;
   logic        fin_ff,    fin_in;

   // result register
   logic           out_valid_ff;
   token_kind_type out_kind_ff;
   logic [31:0]    out_value_ff;
   logic [15:0]    out_item_ff;
   status_type     out_status_ff;
   logic           out_final_ff;

   logic           advance;
   logic           proc;
   logic           have;
   logic           done_now;
   status_type     status_now;
   token_kind_type kind;
   logic [31:0]    val;
   logic [31:0]    acc_shift;
   logic [15:0]    v16;
   logic [15:0]    pool_dec, meth_dec, attr_dec, cattr_dec, item_inc;
   logic [31:0]    pbl_dec;
   logic           do_pool, do_mattr, do_meth, do_cattr;

   assign advance = in_valid_ff && (!out_valid_ff || rsp_chan.ready);
   assign proc    = advance && !fin_ff;
   assign req_chan.ready = !in_valid_ff || advance;

   assign acc_shift = {acc_ff[23:0], in_byte_ff};
   assign v16       = acc_shift[15:0];
   assign pool_dec  = pool_ff - 16'd1;
   assign meth_dec  = meth_ff - 16'd1;
   assign attr_dec  = attr_ff - 16'd1;
   assign cattr_dec = cattr_ff - 16'd1;
   assign item_inc  = item_ff + 16'd1;
   assign pbl_dec   = pbl_ff - 32'd1;

   always_comb begin
      phase_in   = phase_ff;
      bif_in     = bif_ff;
      acc_in     = acc_ff;
      pool_in    = pool_ff;
      meth_in    = meth_ff;
      attr_in    = attr_ff;
      cattr_in   = cattr_ff;
      pbl_in     = pbl_ff;
      item_in    = item_ff;
      fin_in     = fin_ff;
      have       = 1'b0;
      done_now   = 1'b0;
      status_now = ST_OK;
      kind       = TK_MINOR;
      val        = '0;
      do_pool    = 1'b0;
      do_mattr   = 1'b0;
      do_meth    = 1'b0;
      do_cattr   = 1'b0;

      if (proc) begin
         if (is_payload(phase_ff)) begin
            have   = 1'b1;
            kind   = TK_PAYLOAD;
            val    = {24'd0, in_byte_ff};
            pbl_in = pbl_dec;
            if (pbl_dec == 32'd0) begin
               priority case (phase_ff)
                  PH_UTEXT: do_pool  = 1'b1;
                  PH_ABODY: do_mattr = 1'b1;
                  default:  do_cattr = 1'b1;
               endcase
            end
         end else begin
            acc_in = acc_shift;
            bif_in = bif_ff + 2'd1;
            if (bif_ff == field_last(phase_ff)) begin
               acc_in = '0;
               bif_in = '0;
               have   = 1'b1;
               kind   = phase_kind(phase_ff);
               val    = acc_shift;
               unique case (phase_ff)
                  PH_MAGIC: begin
                     if (acc_shift != CLASS_MAGIC) begin
                        done_now   = 1'b1;
                        status_now = ST_BAD_MAGIC;
                     end else begin
                        phase_in = PH_MINOR;
                     end
                  end
                  PH_MINOR:  phase_in = PH_MAJOR;
                  PH_MAJOR:  phase_in = PH_PCOUNT;
                  PH_PCOUNT: begin
                     pool_in = v16 - 16'd1;
                     if (v16 == 16'd1) begin
                        phase_in = PH_ACC;
                     end else begin
                        item_in  = 16'd1;
                        phase_in = PH_TAG;
                     end
                  end
                  PH_TAG: begin
                     priority if (acc_shift == TAG_CLASS)     phase_in = PH_CLASS;
                     else if (acc_shift == TAG_METHODREF)     phase_in = PH_MRCLS;
                     else if (acc_shift == TAG_NAMETYPE)      phase_in = PH_NATNAME;
                     else if (acc_shift == TAG_UTF8)          phase_in = PH_ULEN;
                     else begin
                        done_now   = 1'b1;
                        status_now = ST_BAD_TAG;
                     end
                  end
                  PH_CLASS:   do_pool  = 1'b1;
                  PH_MRCLS:   phase_in = PH_MRNAT;
                  PH_MRNAT:   do_pool  = 1'b1;
                  PH_NATNAME: phase_in = PH_NATDESC;
                  PH_NATDESC: do_pool  = 1'b1;
                  PH_ULEN: begin
                     pbl_in = {16'd0, v16};
                     if (v16 == 16'd0) do_pool = 1'b1;
                     else phase_in = PH_UTEXT;
                  end
                  PH_ACC:   phase_in = PH_THIS;
                  PH_THIS:  phase_in = PH_SUPER;
                  PH_SUPER: phase_in = PH_IFC;
                  PH_IFC, PH_FIELDS: begin
                     if (v16 != 16'd0) begin
                        done_now   = 1'b1;
                        status_now = ST_NOT_IMPL;
                     end else begin
                        phase_in = (phase_ff == PH_IFC) ? PH_FIELDS : PH_MCOUNT;
                     end
                  end
                  PH_MCOUNT: begin
                     meth_in = v16;
                     item_in = '0;
                     phase_in = (v16 == 16'd0) ? PH_CACNT : PH_MACC;
                  end
                  PH_MACC:  phase_in = PH_MNAME;
                  PH_MNAME: phase_in = PH_MDESC;
                  PH_MDESC: phase_in = PH_MACNT;
                  PH_MACNT: begin
                     attr_in = v16;
                     if (v16 == 16'd0) do_meth = 1'b1;
                     else phase_in = PH_ANAME;
                  end
                  PH_ANAME: phase_in = PH_ALEN;
                  PH_ALEN: begin
                     pbl_in = acc_shift;
                     if (acc_shift == 32'd0) do_mattr = 1'b1;
                     else phase_in = PH_ABODY;
                  end
                  PH_CACNT: begin
                     cattr_in = v16;
                     if (v16 == 16'd0) done_now = 1'b1;
                     else phase_in = PH_CANAME;
                  end
                  PH_CANAME: phase_in = PH_CALEN;
                  PH_CALEN: begin
                     pbl_in = acc_shift;
                     if (acc_shift == 32'd0) do_cattr = 1'b1;
                     else phase_in = PH_CABODY;
                  end
                  default: ;
               endcase
               // a good magic word gives no token
               if (phase_ff == PH_MAGIC && !done_now) have = 1'b0;
            end
         end

         // entry and list bookkeeping; an attribute end may close its method too
         if (do_pool) begin
            pool_in = pool_dec;
            if (pool_dec == 16'd0) begin
               item_in  = '0;
               phase_in = PH_ACC;
            end else begin
               item_in  = item_inc;
               phase_in = PH_TAG;
            end
         end
         if (do_mattr) begin
            attr_in = attr_dec;
            if (attr_dec == 16'd0) do_meth = 1'b1;
            else phase_in = PH_ANAME;
         end
         if (do_meth) begin
            meth_in = meth_dec;
            if (meth_dec == 16'd0) begin
               item_in  = '0;
               phase_in = PH_CACNT;
            end else begin
               item_in  = item_inc;
               phase_in = PH_MACC;
            end
         end
         if (do_cattr) begin
            item_in  = item_inc;
            cattr_in = cattr_dec;
            if (cattr_dec == 16'd0) done_now = 1'b1;
            else phase_in = PH_CANAME;
         end

         if (!done_now && in_eof_ff) begin
            done_now   = 1'b1;
            status_now = ST_TRUNC;
            if (!have) begin
               kind = TK_MINOR;
               val  = '0;
            end
         end
         fin_in = done_now;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         phase_ff     <= PH_MAGIC;
         bif_ff       <= '0;
         acc_ff       <= '0;
         pool_ff      <= '0;
         meth_ff      <= '0;
         attr_ff      <= '0;
         cattr_ff     <= '0;
         pbl_ff       <= '0;
         item_ff      <= '0;
         fin_ff       <= 1'b0;
      end else begin
         if (req_chan.valid && req_chan.ready) begin
            in_valid_ff <= 1'b1;
         end else if (advance) begin
            in_valid_ff <= 1'b0;
         end

         if (advance) begin
            out_valid_ff <= proc && (have || done_now);
         end else if (rsp_chan.ready) begin
            out_valid_ff <= 1'b0;
         end

         phase_ff <= phase_in;
         bif_ff   <= bif_in;
         acc_ff   <= acc_in;
         pool_ff  <= pool_in;
         meth_ff  <= meth_in;
         attr_ff  <= attr_in;
         cattr_ff <= cattr_in;
         pbl_ff   <= pbl_in;
         item_ff  <= item_in;
         fin_ff   <= fin_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_chan.valid && req_chan.ready) begin
         in_byte_ff <= req_chan.data_byte;
         in_eof_ff  <= req_chan.end_of_file;
      end
      if (advance) begin
         out_kind_ff   <= kind;
         out_value_ff  <= val;
         out_item_ff   <= item_ff;
         out_status_ff <= status_now;
         out_final_ff  <= done_now;
      end
   end

   assign rsp_chan.valid       = out_valid_ff;
   assign rsp_chan.token_kind  = out_kind_ff;
   assign rsp_chan.token_value = out_value_ff;
   assign rsp_chan.item_number = out_item_ff;
   assign rsp_chan.status      = out_status_ff;
   assign rsp_chan.final_res   = out_final_ff;

endmodule

`default_nettype wire

/* src/cfsp_checker.sv */
// ----------------------------------------------------------------------------
// cfsp_checker
// Port-level checks on the token stream of the class file parser.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module cfsp_checker
   import cfsp_pkg::*;
(
   input wire        clock,
   input wire        reset,
   input wire        rsp_valid,
   input wire        rsp_ready,
   input wire [4:0]  rsp_token_kind,
   input wire [2:0]  rsp_status,
   input wire        rsp_final_res
);

   `CFSP_ASSERT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready |=> rsp_valid, "token dropped while stalled")
   `CFSP_ASSERT(a_error_is_final, clock, reset, rsp_valid && rsp_status != ST_OK |-> rsp_final_res, "error token not final")
   `CFSP_ASSERT(a_codes_range, clock, reset, rsp_valid |-> (rsp_status <= ST_NOT_IMPL) && (rsp_token_kind <= TK_LAST), "token code out of range")
   `CFSP_ASSERT(a_quiet_after_final, clock, reset, rsp_valid && rsp_ready && rsp_final_res |=> !rsp_valid, "item after final token")
   `CFSP_ASSERT_ALWAYS(a_reset_empty, clock, reset |=> !rsp_valid, "token present after reset")

endmodule

bind class_file_stream_parser cfsp_checker u_cfsp_checker (
   .clock          (clock),
   .reset          (reset),
   .rsp_valid      (rsp_chan.valid),
   .rsp_ready      (rsp_chan.ready),
   .rsp_token_kind (rsp_chan.token_kind),
   .rsp_status     (rsp_chan.status),
   .rsp_final_res  (rsp_chan.final_res)
);

`default_nettype wire

/* sim/class_file_stream_parser_test.sv */
// ----------------------------------------------------------------------------
// class_file_stream_parser_test
// Streams one class file into the parser with random gaps on both channels
// and compares every token with a predictor of the parse. The way the file
// ends (clean, no class attributes, truncated, bad magic, bad tag, interfaces or fields present,
// wrapped pool count) is drawn at random, since only one reset is applied.
// ----------------------------------------------------------------------------
`default_nettype none

module class_file_stream_parser_test;
   import cfsp_pkg::*;

   localparam int unsigned CYCLE_LIMIT = 200000;
   localparam int unsigned HOLD_CYCLES = 120;
   localparam int unsigned DIRECTED_ENTRIES = 5;
   localparam int          ITEM_TARGET = 400;

   typedef enum {
      END_CLEAN, END_NO_CLASS_ATTRS, END_TRUNCATED, END_BAD_TAG,
      END_IFC_PRESENT, END_FIELDS_PRESENT, END_BAD_MAGIC, END_POOL_WRAP
   } ending_type;

   typedef struct {
      token_kind_type kind;
      logic [31:0]    value;
      logic [15:0]    item;
      status_type     status;
      logic           fin;
   } token_type;

   logic clock;
   logic reset;

   cfsp_req_if req_chan ();
   cfsp_rsp_if rsp_chan ();

   class_file_stream_parser dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   always begin
      clock = 1'b0;
      #10;
      clock = 1'b1;
      #10;
   end

   // parse state as predicted
   phase_type   pstate;
   int unsigned byte_pos;
   logic [31:0] field_acc;
   logic [15:0] pool_left;
   logic [15:0] methods_left;
   logic [15:0] mattrs_left;
   logic [15:0] cattrs_left;
   logic [31:0] body_left;
   logic [15:0] item_idx;
   bit          parse_done;
   bit          end_now;
   status_type  st_now;

   token_type   expected_tokens[$];
   int unsigned fault_count;
   int unsigned tokens_seen;
   int unsigned cycle_count;

   ending_type  ending;
   bit          empty_pool;
   int unsigned n_random;
   int          bad_at;
   int          cut_at;
   int          bytes_sent;
   bit          gaps_on;
   bit          hold_request;

   function automatic int unsigned bytes_in_field(phase_type ph);
      case (ph)
         PH_MAGIC, PH_ALEN, PH_CALEN:   return 4;
         PH_TAG:                        return 1;
         PH_UTEXT, PH_ABODY, PH_CABODY: return 0;
         default:                       return 2;
      endcase
   endfunction

   function automatic token_kind_type token_for_phase(phase_type ph);
      case (ph)
         PH_MAJOR:            return TK_MAJOR;
         PH_PCOUNT:           return TK_POOL_COUNT;
         PH_TAG:              return TK_POOL_TAG;
         PH_CLASS:            return TK_CLASS_NAME;
         PH_MRCLS:            return TK_MR_CLASS;
         PH_MRNAT:            return TK_MR_NAT;
         PH_NATNAME:          return TK_NAT_NAME;
         PH_NATDESC:          return TK_NAT_DESC;
         PH_ULEN:             return TK_UTF8_LEN;
         PH_ACC:              return TK_ACCESS;
         PH_THIS:             return TK_THIS;
         PH_SUPER:            return TK_SUPER;
         PH_IFC:              return TK_IFC_COUNT;
         PH_FIELDS:           return TK_FLD_COUNT;
         PH_MCOUNT:           return TK_MTH_COUNT;
         PH_MACC:             return TK_MTH_ACCESS;
         PH_MNAME:            return TK_MTH_NAME;
         PH_MDESC:            return TK_MTH_DESC;
         PH_MACNT:            return TK_MTH_ACOUNT;
         PH_ANAME, PH_CANAME: return TK_ATTR_NAME;
         PH_ALEN, PH_CALEN:   return TK_ATTR_LEN;
         PH_CACNT:            return TK_CLS_ACOUNT;
         PH_UTEXT, PH_ABODY, PH_CABODY: return TK_PAYLOAD;
         default:             return TK_MINOR;
      endcase
   endfunction

   task automatic stop_parse(input status_type code);
      st_now = code;
      end_now = 1'b1;
   endtask

   task automatic pool_entry_closed();
      item_idx = item_idx + 16'd1;
      pool_left = pool_left - 16'd1;
      if (pool_left == 16'd0) begin
         item_idx = 16'd0;
         pstate = PH_ACC;
      end else begin
         pstate = PH_TAG;
      end
   endtask

   task automatic method_closed();
      item_idx = item_idx + 16'd1;
      methods_left = methods_left - 16'd1;
      if (methods_left == 16'd0) begin
         item_idx = 16'd0;
         pstate = PH_CACNT;
      end else begin
         pstate = PH_MACC;
      end
   endtask

   task automatic method_attr_closed();
      mattrs_left = mattrs_left - 16'd1;
      if (mattrs_left == 16'd0) method_closed();
      else pstate = PH_ANAME;
   endtask

   task automatic class_attr_closed();
      item_idx = item_idx + 16'd1;
      cattrs_left = cattrs_left - 16'd1;
      if (cattrs_left == 16'd0) end_now = 1'b1;
      else pstate = PH_CANAME;
   endtask

   task automatic field_closed(input phase_type ph, input logic [31:0] v);
      logic [15:0] v16;
      v16 = v[15:0];
      case (ph)
         PH_MAGIC: begin
            if (v != CLASS_MAGIC) stop_parse(ST_BAD_MAGIC);
            else pstate = PH_MINOR;
         end
         PH_MINOR: pstate = PH_MAJOR;
         PH_MAJOR: pstate = PH_PCOUNT;
         PH_PCOUNT: begin
            // a count of zero wraps round to 65535 entries
            pool_left = v16 - 16'd1;
            if (pool_left == 16'd0) begin
               pstate = PH_ACC;
            end else begin
               item_idx = 16'd1;
               pstate = PH_TAG;
            end
         end
         PH_TAG: begin
            if (v == TAG_CLASS) pstate = PH_CLASS;
            else if (v == TAG_METHODREF) pstate = PH_MRCLS;
            else if (v == TAG_NAMETYPE) pstate = PH_NATNAME;
            else if (v == TAG_UTF8) pstate = PH_ULEN;
            else stop_parse(ST_BAD_TAG);
         end
         PH_CLASS, PH_MRNAT, PH_NATDESC: pool_entry_closed();
         PH_MRCLS:   pstate = PH_MRNAT;
         PH_NATNAME: pstate = PH_NATDESC;
         PH_ULEN: begin
            body_left = {16'd0, v16};
            if (v16 == 16'd0) pool_entry_closed();
            else pstate = PH_UTEXT;
         end
         PH_ACC:   pstate = PH_THIS;
         PH_THIS:  pstate = PH_SUPER;
         PH_SUPER: pstate = PH_IFC;
         PH_IFC: begin
            if (v16 != 16'd0) stop_parse(ST_NOT_IMPL);
            else pstate = PH_FIELDS;
         end
         PH_FIELDS: begin
            if (v16 != 16'd0) stop_parse(ST_NOT_IMPL);
            else pstate = PH_MCOUNT;
         end
         PH_MCOUNT: begin
            methods_left = v16;
            item_idx = 16'd0;
            if (v16 == 16'd0) pstate = PH_CACNT;
            else pstate = PH_MACC;
         end
         PH_MACC:  pstate = PH_MNAME;
         PH_MNAME: pstate = PH_MDESC;
         PH_MDESC: pstate = PH_MACNT;
         PH_MACNT: begin
            mattrs_left = v16;
            if (v16 == 16'd0) method_closed();
            else pstate = PH_ANAME;
         end
         PH_ANAME: pstate = PH_ALEN;
         PH_ALEN: begin
            body_left = v;
            if (v == 32'd0) method_attr_closed();
            else pstate = PH_ABODY;
         end
         PH_CACNT: begin
            cattrs_left = v16;
            if (v16 == 16'd0) end_now = 1'b1;
            else pstate = PH_CANAME;
         end
         PH_CANAME: pstate = PH_CALEN;
         PH_CALEN: begin
            body_left = v;
            if (v == 32'd0) class_attr_closed();
            else pstate = PH_CABODY;
         end
         default: ;
      endcase
   endtask

   // works out the token, if any, caused by one accepted byte
   task automatic predict_byte(input logic [7:0] b, input logic eof);
      token_type   t;
      bit          have;
      phase_type   ph;
      int unsigned need;
      if (parse_done) return;
      ph = pstate;
      need = bytes_in_field(ph);
      have = 1'b0;
      end_now = 1'b0;
      st_now = ST_OK;
      t.kind = TK_MINOR;
      t.value = 32'd0;
      t.item = item_idx;
      if (need == 0) begin
         have = 1'b1;
         t.kind = TK_PAYLOAD;
         t.value = {24'd0, b};
         body_left = body_left - 32'd1;
         if (body_left == 32'd0) begin
            case (ph)
               PH_UTEXT: pool_entry_closed();
               PH_ABODY: method_attr_closed();
               default:  class_attr_closed();
            endcase
         end
      end else begin
         field_acc = {field_acc[23:0], b};
         byte_pos++;
         if (byte_pos >= need) begin
            t.value = field_acc;
            t.kind = token_for_phase(ph);
            field_acc = 32'd0;
            byte_pos = 0;
            have = 1'b1;
            field_closed(ph, t.value);
            // a good magic word gives no token
            if (ph == PH_MAGIC && !end_now) have = 1'b0;
         end
      end
      if (!end_now && eof) begin
         end_now = 1'b1;
         st_now = ST_TRUNC;
         if (!have) begin
            t.kind = TK_MINOR;
            t.value = 32'd0;
         end
      end
      if (!have && !end_now) return;
      if (end_now) parse_done = 1'b1;
      t.status = st_now;
      t.fin = end_now;
      expected_tokens.insert(expected_tokens.size(), t);
   endtask

   function automatic int unsigned pick_gap();
      if ($urandom_range(0, 9) < 8) return $urandom_range(0, 2);
      return $urandom_range(6, 30);
   endfunction

   task automatic send_byte(input logic [7:0] value, input logic last);
      int unsigned gap;
      logic        eof_bit;
      logic        taken;
      eof_bit = last || (bytes_sent == cut_at);
      gap = gaps_on ? pick_gap() : 0;
      if (gap > 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_chan.valid <= 1'b1;
      req_chan.data_byte <= value;
      req_chan.end_of_file <= eof_bit;
      // ready sampled mid-cycle, the item is taken at the following edge
      do begin
         @(negedge clock);
         taken = req_chan.ready;
         @(posedge clock);
      end while (!taken);
      predict_byte(value, eof_bit);
      bytes_sent++;
   endtask

   task automatic send_half(input logic [15:0] v, input logic last);
      send_byte(v[15:8], 1'b0);
      send_byte(v[7:0], last);
   endtask

   task automatic send_word(input logic [31:0] v, input logic last);
      send_half(v[31:16], 1'b0);
      send_half(v[15:0], last);
   endtask

   task automatic note_fault(input string what);
      fault_count++;
      if (fault_count <= 10) $display("%s", what);
   endtask

   task automatic check_token();
      token_type want;
      if (expected_tokens.size() == 0) begin
         note_fault($sformatf({"token %0d unexpected: kind %0d value %h item %0d",
                               " status %0d final %0b"},
                              tokens_seen, rsp_chan.token_kind, rsp_chan.token_value,
                              rsp_chan.item_number, rsp_chan.status, rsp_chan.final_res));
      end else begin
         want = expected_tokens.pop_front();
         if (rsp_chan.token_kind !== want.kind || rsp_chan.token_value !== want.value ||
             rsp_chan.item_number !== want.item || rsp_chan.status !== want.status ||
             rsp_chan.final_res !== want.fin)
            note_fault($sformatf({"token %0d: expected kind %0d value %h item %0d status %0d",
                                  " final %0b, got kind %0d value %h item %0d status %0d final %0b"},
                                 tokens_seen, want.kind, want.value, want.item, want.status,
                                 want.fin, rsp_chan.token_kind, rsp_chan.token_value,
                                 rsp_chan.item_number, rsp_chan.status, rsp_chan.final_res));
      end
      tokens_seen++;
   endtask

   // handshake completes at the next rising edge
   always @(negedge clock) begin
      if (!reset && rsp_chan.valid && rsp_chan.ready) check_token();
   end

   initial begin : token_sink
      int unsigned stall_left;
      stall_left = 0;
      rsp_chan.ready = 1'b0;
      forever begin
         @(posedge clock);
         if (stall_left == 0) begin
            if (hold_request) begin
               hold_request = 1'b0;
               stall_left = HOLD_CYCLES;
            end else if (gaps_on && $urandom_range(0, 3) == 0) begin
               stall_left = pick_gap();
            end
         end
         if (stall_left > 0) begin
            rsp_chan.ready <= 1'b0;
            stall_left--;
         end else begin
            rsp_chan.ready <= 1'b1;
         end
      end
   end

   initial begin : watchdog
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("== FAIL ==");
      $finish;
   end

   task automatic test_header();
      logic [31:0] magic;
      logic [15:0] pool_count;
      gaps_on = 1'b0;
      // long receiver stall right from the start, whatever the ending
      hold_request = 1'b1;
      magic = CLASS_MAGIC;
      if (ending == END_BAD_MAGIC)
         magic = ($urandom_range(0, 1) == 0) ? 32'h0 : CLASS_MAGIC ^ (32'h1 << $urandom_range(0, 31));
      pool_count = 16'(DIRECTED_ENTRIES + n_random + 1);
      if (empty_pool) pool_count = 16'd1;
      if (ending == END_POOL_WRAP) pool_count = 16'd0;
      send_word(magic, 1'b0);
      send_half(16'hFFFF, 1'b0);
      send_half(16'h0000, 1'b0);
      send_half(pool_count, 1'b0);
   endtask

   task automatic test_pool_directed();
      if (parse_done || empty_pool) return;
      gaps_on = 1'($urandom_range(0, 1));
      send_byte(TAG_CLASS[7:0], 1'b0);
      send_half(16'hFFFF, 1'b0);
      send_byte(TAG_METHODREF[7:0], 1'b0);
      send_half(16'h0000, 1'b0);
      send_half(16'hFFFF, 1'b0);
      send_byte(TAG_NAMETYPE[7:0], 1'b0);
      send_half(16'hABCD, 1'b0);
      send_half(16'h0001, 1'b0);
      // empty text, then one byte of text
      send_byte(TAG_UTF8[7:0], 1'b0);
      send_half(16'h0000, 1'b0);
      send_byte(TAG_UTF8[7:0], 1'b0);
      send_half(16'h0001, 1'b0);
      send_byte(8'hFF, 1'b0);
   endtask

   task automatic test_pool_random();
      int unsigned i, k, len;
      logic [7:0]  tag;
      if (parse_done || empty_pool) return;
      gaps_on = $urandom_range(0, 3) != 0;
      for (i = 0; i < n_random && !parse_done; i++) begin
         // receiver stalls for a long stretch while bytes keep coming
         if (i == n_random / 2) hold_request = 1'b1;
         if (i == bad_at) begin
            case ($urandom_range(0, 2))
               0: tag = 8'h00;
               1: tag = 8'hFF;
               default: begin
                  do tag = 8'($urandom_range(0, 255));
                  while (tag == TAG_UTF8[7:0] || tag == TAG_CLASS[7:0] ||
                         tag == TAG_METHODREF[7:0] || tag == TAG_NAMETYPE[7:0]);
               end
            endcase
            send_byte(tag, 1'b0);
         end else begin
            case ($urandom_range(0, 3))
               0: begin
                  send_byte(TAG_CLASS[7:0], 1'b0);
                  send_half(16'($urandom_range(0, 16'hFFFF)), 1'b0);
               end
               1: begin
                  send_byte(TAG_METHODREF[7:0], 1'b0);
                  send_half(16'($urandom_range(0, 16'hFFFF)), 1'b0);
                  send_half(16'($urandom_range(0, 16'hFFFF)), 1'b0);
               end
               2: begin
                  send_byte(TAG_NAMETYPE[7:0], 1'b0);
                  send_half(16'($urandom_range(0, 16'hFFFF)), 1'b0);
                  send_half(16'($urandom_range(0, 16'hFFFF)), 1'b0);
               end
               default: begin
                  len = $urandom_range(0, 10);
                  send_byte(TAG_UTF8[7:0], 1'b0);
                  send_half(len[15:0], 1'b0);
                  for (k = 0; k < len; k++) send_byte(8'($urandom_range(0, 255)), 1'b0);
               end
            endcase
         end
      end
   endtask

   task automatic test_class_info();
      logic [15:0] ifc, flds;
      if (parse_done) return;
      gaps_on = $urandom_range(0, 3) != 0;
      ifc = (ending == END_IFC_PRESENT) ? 16'($urandom_range(1, 16'hFFFF)) : 16'd0;
      flds = (ending == END_FIELDS_PRESENT) ? 16'($urandom_range(1, 16'hFFFF)) : 16'd0;
      send_half(16'($urandom_range(0, 16'hFFFF)), 1'b0);
      send_half(16'($urandom_range(0, 16'hFFFF)), 1'b0);
      send_half(16'($urandom_range(0, 16'hFFFF)), 1'b0);
      send_half(ifc, 1'b0);
      if (parse_done) return;
      send_half(flds, 1'b0);
   endtask

   task automatic test_methods();
      int unsigned count, acount, len, m, a, k;
      if (parse_done) return;
      gaps_on = $urandom_range(0, 3) != 0;
      count = $urandom_range(0, 4);
      send_half(count[15:0], 1'b0);
      for (m = 0; m < count && !parse_done; m++) begin
         send_half(16'($urandom_range(0, 16'hFFFF)), 1'b0);
         send_half(16'($urandom_range(0, 16'hFFFF)), 1'b0);
         send_half(16'($urandom_range(0, 16'hFFFF)), 1'b0);
         acount = $urandom_range(0, 3);
         send_half(acount[15:0], 1'b0);
         for (a = 0; a < acount; a++) begin
            send_half(16'($urandom_range(0, 16'hFFFF)), 1'b0);
            len = $urandom_range(0, 10);
            send_word(len, 1'b0);
            for (k = 0; k < len; k++) send_byte(8'($urandom_range(0, 255)), 1'b0);
         end
      end
   endtask

   task automatic test_class_attributes();
      int unsigned count, len, a, k;
      bit          last_attr;
      if (parse_done) return;
      gaps_on = $urandom_range(0, 3) != 0;
      count = (ending == END_NO_CLASS_ATTRS) ? 0 : $urandom_range(1, 3);
      send_half(count[15:0], count == 0);
      for (a = 0; a < count; a++) begin
         last_attr = (a == count - 1);
         send_half(16'($urandom_range(0, 16'hFFFF)), 1'b0);
         len = $urandom_range(0, 12);
         send_word(len, last_attr && len == 0);
         for (k = 0; k < len; k++)
            send_byte(8'($urandom_range(0, 255)), last_attr && k == len - 1);
      end
   endtask

   // bytes after the end are dropped by the block; they also pad the run
   // out to its item count
   task automatic test_trailing();
      int unsigned k;
      gaps_on = 1'($urandom_range(0, 1));
      for (k = 0; k < 16 || bytes_sent < ITEM_TARGET; k++)
         send_byte(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
   endtask

   initial begin : run
      int unsigned pick;
      reset = 1'b1;
      req_chan.valid = 1'b0;
      req_chan.data_byte = 8'd0;
      req_chan.end_of_file = 1'b0;
      hold_request = 1'b0;
      gaps_on = 1'b0;
      fault_count = 0;
      tokens_seen = 0;
      bytes_sent = 0;
      pstate = PH_MAGIC;
      byte_pos = 0;
      field_acc = 32'd0;
      pool_left = 16'd0;
      methods_left = 16'd0;
      mattrs_left = 16'd0;
      cattrs_left = 16'd0;
      body_left = 32'd0;
      item_idx = 16'd0;
      parse_done = 1'b0;

      pick = $urandom_range(0, 99);
      if (pick < 35) ending = END_CLEAN;
      else if (pick < 45) ending = END_NO_CLASS_ATTRS;
      else if (pick < 60) ending = END_TRUNCATED;
      else if (pick < 70) ending = END_BAD_TAG;
      else if (pick < 77) ending = END_IFC_PRESENT;
      else if (pick < 84) ending = END_FIELDS_PRESENT;
      else if (pick < 90) ending = END_BAD_MAGIC;
      else ending = END_POOL_WRAP;
      n_random = $urandom_range(40, 50);
      bad_at = -1;
      if (ending == END_BAD_TAG) bad_at = $urandom_range(0, n_random - 1);
      if (ending == END_POOL_WRAP) bad_at = n_random - 1;
      cut_at = (ending == END_TRUNCATED) ? $urandom_range(10, 300) : -1;
      empty_pool = (ending != END_BAD_TAG && ending != END_POOL_WRAP &&
                    $urandom_range(0, 9) == 0);

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      test_header();
      test_pool_directed();
      test_pool_random();
      test_class_info();
      test_methods();
      test_class_attributes();
      test_trailing();

      req_chan.valid <= 1'b0;
      gaps_on = 1'b0;
      while (expected_tokens.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      if (fault_count == 0 && expected_tokens.size() == 0) $display("== PASS ==");
      else $display("== FAIL ==");
      $finish;
   end

endmodule

`default_nettype wire
